// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/blmm_pkg.sv =====
package blmm_pkg;
    localparam int MAP_W_MAX = 256;
    localparam int MAP_H_MAX = 256;
    localparam int COL_BITS = $clog2(MAP_W_MAX);
    localparam int ROW_BITS = $clog2(MAP_H_MAX);
    localparam int BANK_ADDR_BITS = COL_BITS + ROW_BITS - 2;
    localparam int BANK_DEPTH = (MAP_W_MAX * MAP_H_MAX) / 4;
    localparam logic [19:0] NEAREST_STEP_LIMIT = 20'd64880;
    localparam logic [16:0] FADE_ONE = 17'h10000;

    localparam logic [2:0] CFG_STEP     = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_X = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd2;
    localparam logic [2:0] CFG_LIGHT    = 3'd3;
    localparam logic [2:0] CFG_MAP_W    = 3'd4;
    localparam logic [2:0] CFG_MAP_H    = 3'd5;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic                      we;
        logic [1:0]                bank;
        logic [BANK_ADDR_BITS-1:0] addr;
        logic [7:0]                data;
    } t_wr;
endpackage

// ===== hdl/blmm_ifs.sv =====
interface blmm_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [11:0] coord_x;
    logic [11:0] coord_y;
    logic [7:0]  attn_value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    modport source (output valid, cmd, coord_x, coord_y, attn_value, red, green, blue,
                    input ready);
    modport sink (input valid, cmd, coord_x, coord_y, attn_value, red, green, blue,
                  output ready);
endinterface

interface blmm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== hdl/blmm_attn_mem.sv =====
module blmm_attn_mem (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  blmm_pkg::t_wr                                 i_wr,
    input  logic [3:0][blmm_pkg::BANK_ADDR_BITS-1:0]      i_raddr,
    output logic [3:0][7:0]                               o_rdata
);
    // Four banks split by column and row parity, so the four corners of a
    // bilinear cell always sit in different banks.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] r_mem [blmm_pkg::BANK_DEPTH];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_wr.we && i_wr.bank == 2'(b)) begin
                    r_mem[i_wr.addr] <= i_wr.data;
                end
                o_rdata[b] <= r_mem[i_raddr[b]];
            end
        end
    end
endmodule

// ===== hdl/bilinear_light_map_modulate_core.sv =====
// Bilinear light-map modulation core.
// Input channel i_pix carries one beat per item: cmd 0 writes attn_value into
// the attenuation map at (coord_x, coord_y) when both are below 256, cmd 1
// shades the pixel red, green, blue taken at texture position (coord_x,
// coord_y). Each shade beat gives one beat on o_pix; load beats give none.
// Load the map before shading from it. The core is a ten-stage pipeline and
// takes one beat every cycle while o_pix is not stalled. The map sits in four
// parity banks with one read port each, so all four bilinear corners are
// fetched in the same cycle. Loads write the map in the same stage that shades
// read it, keeping program order.
// The configuration port must be written by the user with i_cfg_we, i_cfg_idx and
// i_cfg_data only while the core is idle; the core does not enforce this.
// Reset returns the registers to their defaults and empties the pipeline; the
// map contents are kept and are undefined before they are first loaded.
// When the receiver holds o_pix.ready low with a result waiting, the whole
// pipeline holds and i_pix.ready drops in the same cycle; nothing is lost.
`include "assert_macros.svh"
module bilinear_light_map_modulate_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [19:0]       i_cfg_data,
    blmm_in_if.sink           i_pix,
    blmm_out_if.source        o_pix
);
    localparam int NST = 9;

    logic [19:0] r_step;
    logic [7:0]  r_org_x;
    logic [7:0]  r_org_y;
    logic [15:0] r_light;
    logic [8:0]  r_map_w;
    logic [8:0]  r_map_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 20'd65536;
            r_org_x <= '0;
            r_org_y <= '0;
            r_light <= 16'd256;
            r_map_w <= 9'd256;
            r_map_h <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                blmm_pkg::CFG_STEP:     r_step  <= i_cfg_data;
                blmm_pkg::CFG_ORIGIN_X: r_org_x <= i_cfg_data[7:0];
                blmm_pkg::CFG_ORIGIN_Y: r_org_y <= i_cfg_data[7:0];
                blmm_pkg::CFG_LIGHT:    r_light <= i_cfg_data[15:0];
                blmm_pkg::CFG_MAP_W:    r_map_w <= i_cfg_data[8:0];
                blmm_pkg::CFG_MAP_H:    r_map_h <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_ov;
    assign en = !r_ov || o_pix.ready;
    assign i_pix.ready = en;

    logic [NST:1]       r_v;
    logic [NST:1]       r_cmd;
    blmm_pkg::t_rgb     r_rgb [NST:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[NST-1:1], i_pix.valid};
            r_ov <= r_v[NST] && r_cmd[NST] == blmm_pkg::CMD_SHADE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd    <= {r_cmd[NST-1:1], i_pix.cmd};
            r_rgb[1] <= '{i_pix.red, i_pix.green, i_pix.blue};
            for (int s = 2; s <= NST; s++) begin
                r_rgb[s] <= r_rgb[s-1];
            end
        end
    end

    // Stage 1: input capture.
    logic [11:0] r_cx1, r_cy1;
    logic [7:0]  r_attn1;
    // Stage 2: map position.
    logic [32:0] r_px2, r_py2;
    logic [11:0] r_cx2, r_cy2;
    logic [7:0]  r_attn2;
    // Stage 3: bank addresses and weights.
    logic [3:0][blmm_pkg::BANK_ADDR_BITS-1:0] r_raddr3;
    logic [3:0][16:0] r_wx3, r_wy3;
    logic [3:0]       r_use3;
    blmm_pkg::t_wr    r_wr3;
    // Stage 4: map data.
    logic [3:0][7:0]  rdata4;
    logic [3:0][16:0] r_wx4, r_wy4;
    logic [3:0]       r_use4;
    // Stages 5 to 10.
    logic [3:0][24:0] r_p5;
    logic [3:0][16:0] r_wy5;
    logic [3:0][41:0] r_q6;
    logic [15:0]      r_sample7;
    logic [31:0]      r_gain8;
    logic [2:0][39:0] r_ch9;
    logic [2:0][7:0]  r_out;

    logic [8:0]  w_lim, h_lim;
    logic        nearest;
    logic [16:0] ix, iy;
    logic [7:0]  ixc, iyc;
    logic [16:0] fx, fy;
    logic [3:0][blmm_pkg::BANK_ADDR_BITS-1:0] n_raddr;
    logic [3:0][16:0] n_wx, n_wy;
    logic [3:0]       n_use;
    logic [8:0]  col_n, row_n;
    logic [41:0] acc;

    always_comb begin
        w_lim = (r_map_w < 9'd2) ? 9'd2 : (r_map_w > 9'(blmm_pkg::MAP_W_MAX)) ?
                9'(blmm_pkg::MAP_W_MAX) : r_map_w;
        h_lim = (r_map_h < 9'd2) ? 9'd2 : (r_map_h > 9'(blmm_pkg::MAP_H_MAX)) ?
                9'(blmm_pkg::MAP_H_MAX) : r_map_h;
        nearest = r_step > blmm_pkg::NEAREST_STEP_LIMIT;
        ix = r_px2[32:16];
        iy = r_py2[32:16];
        if (nearest) begin
            ixc = (ix > 17'(w_lim - 9'd1)) ? 8'(w_lim - 9'd1) : ix[7:0];
            iyc = (iy > 17'(h_lim - 9'd1)) ? 8'(h_lim - 9'd1) : iy[7:0];
            fx  = '0;
            fy  = '0;
        end else begin
            if (ix >= 17'(w_lim - 9'd1)) begin
                ixc = 8'(w_lim - 9'd2);
                fx  = blmm_pkg::FADE_ONE;
            end else begin
                ixc = ix[7:0];
                fx  = {1'b0, r_px2[15:0]};
            end
            if (iy >= 17'(h_lim - 9'd1)) begin
                iyc = 8'(h_lim - 9'd2);
                fy  = blmm_pkg::FADE_ONE;
            end else begin
                iyc = iy[7:0];
                fy  = {1'b0, r_py2[15:0]};
            end
        end
        col_n = {1'b0, ixc} + 9'd1;
        row_n = {1'b0, iyc} + 9'd1;
        for (int b = 0; b < 4; b++) begin
            n_wx[b] = (ixc[0] == b[0]) ? blmm_pkg::FADE_ONE - fx : fx;
            n_wy[b] = (iyc[0] == b[1]) ? blmm_pkg::FADE_ONE - fy : fy;
            n_use[b] = n_wx[b] != '0 && n_wy[b] != '0;
            n_raddr[b] = {(iyc[0] == b[1]) ? iyc[7:1] : row_n[7:1],
                          (ixc[0] == b[0]) ? ixc[7:1] : col_n[7:1]};
        end
        acc = r_q6[0] + r_q6[1] + r_q6[2] + r_q6[3];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx1   <= i_pix.coord_x;
            r_cy1   <= i_pix.coord_y;
            r_attn1 <= i_pix.attn_value;

            r_px2   <= 33'(r_step * r_cx1) + {9'd0, r_org_x, 16'd0};
            r_py2   <= 33'(r_step * r_cy1) + {9'd0, r_org_y, 16'd0};
            r_cx2   <= r_cx1;
            r_cy2   <= r_cy1;
            r_attn2 <= r_attn1;

            r_raddr3   <= n_raddr;
            r_wx3      <= n_wx;
            r_wy3      <= n_wy;
            r_use3     <= n_use;
            r_wr3.we   <= r_v[2] && r_cmd[2] == blmm_pkg::CMD_LOAD &&
                          r_cx2 < 12'(blmm_pkg::MAP_W_MAX) &&
                          r_cy2 < 12'(blmm_pkg::MAP_H_MAX);
            r_wr3.bank <= {r_cy2[0], r_cx2[0]};
            r_wr3.addr <= {r_cy2[blmm_pkg::ROW_BITS-1:1], r_cx2[blmm_pkg::COL_BITS-1:1]};
            r_wr3.data <= r_attn2;

            r_wx4  <= r_wx3;
            r_wy4  <= r_wy3;
            r_use4 <= r_use3;

            for (int b = 0; b < 4; b++) begin
                r_p5[b] <= 25'((r_use4[b] ? rdata4[b] : 8'd0) * r_wx4[b]);
                r_q6[b] <= 42'(r_p5[b] * r_wy5[b]);
            end
            r_wy5 <= r_wy4;

            r_sample7 <= acc[39:24];
            r_gain8   <= r_light * r_sample7;
            r_ch9[0]  <= 40'(r_gain8 * r_rgb[8].red);
            r_ch9[1]  <= 40'(r_gain8 * r_rgb[8].green);
            r_ch9[2]  <= 40'(r_gain8 * r_rgb[8].blue);
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= (r_ch9[c][39:24] > 16'd255) ? 8'd255 : r_ch9[c][31:24];
            end
        end
    end

    blmm_attn_mem u_mem (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_wr    ('{we: r_wr3.we && r_v[3], bank: r_wr3.bank, addr: r_wr3.addr,
                    data: r_wr3.data}),
        .i_raddr (r_raddr3),
        .o_rdata (rdata4)
    );

    assign o_pix.valid     = r_ov;
    assign o_pix.out_red   = r_out[0];
    assign o_pix.out_green = r_out[1];
    assign o_pix.out_blue  = r_out[2];

    `ASSERT_IMPLIES(a_stall_blocks_input, i_clk, i_rst_n, r_ov && !o_pix.ready, !i_pix.ready)
    `ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n,
                 en && r_v[NST] && r_cmd[NST] == blmm_pkg::CMD_LOAD, !r_ov)
    `ASSERT_IMPLIES(a_nearest_one_bank, i_clk, i_rst_n,
                    r_v[3] && r_step > blmm_pkg::NEAREST_STEP_LIMIT, $onehot(r_use3))
endmodule
